/* design/kbtr_pkg.sv */
// ----------------------------------------------------------------------------
// kbtr_pkg
// Shared types and constants for the keyboard typematic repeat block.
// ----------------------------------------------------------------------------
package kbtr_pkg;

    // Key command carried with every input transfer
    typedef enum logic [1:0] {
        CMD_PRESS   = 2'd0,
        CMD_HELD    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    // Configuration register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_ESCAPE_CODE     = 2'd0;
    localparam logic [1:0] REG_INITIAL_DELAY   = 2'd1;
    localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd2;

    localparam logic [15:0] ESCAPE_CODE_RST     = 16'd1;
    localparam logic [31:0] INITIAL_DELAY_RST   = 32'd400;
    localparam logic [31:0] REPEAT_INTERVAL_RST = 32'd50;

    // One key slot as held in the slot memory
    typedef struct packed {
        logic        pressed;
        logic [63:0] deadline;
    } slot_entry_t;

endpackage

/* design/kbtr_slot_mem.sv */
// ----------------------------------------------------------------------------
// kbtr_slot_mem
// Single-port-write, single-port-read synchronous slot memory with a
// registered read.
// ----------------------------------------------------------------------------
module kbtr_slot_mem
    import kbtr_pkg::*;
#(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output slot_entry_t       rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  slot_entry_t       wr_data
);

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/keyboard_typematic_repeat.sv */
// ----------------------------------------------------------------------------
// keyboard_typematic_repeat
// Key event handler: tracks the pressed state and repeat deadline of every
// key slot and emits press, repeat and release events.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  -------------------------------------------
//  in       in_valid / in_stall    command, key_code, now_ticks
//  out      out_valid / out_stall  event_valid, event_kind, event_key,
//                                  shutdown_request, key_down
//  cfg      APB (psel, penable)    escape_code, initial_delay_ticks,
//                                  repeat_interval_ticks
//
//  For each item the transfer cycle reads the key's slot from the slot memory;
//  the lookup state then updates and writes it back and loads the output
//  register. in_stall stays high until the lookup state is done.
//  After reset a clearing pass writes every slot with in_stall high;
//  configuration writes are taken throughout.
//  A stalled result holds the lookup stage until the output register drains.
// ----------------------------------------------------------------------------
module keyboard_typematic_repeat
    import kbtr_pkg::*;
#(
    parameter int KEY_SLOTS = 512
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] key_code,
    input  logic [63:0] now_ticks,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        event_valid,
    output logic        event_kind,
    output logic [15:0] event_key,
    output logic        shutdown_request,
    output logic        key_down,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(KEY_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0]  repeat_slot_reg, repeat_slot_next;

    logic [15:0]        escape_code_reg;
    logic [31:0]        initial_delay_reg;
    logic [31:0]        repeat_interval_reg;

    cmd_t               cmd_reg;
    logic [15:0]        key_reg;
    logic [63:0]        now_reg;
    logic               in_range_reg;

    logic               out_valid_reg;
    logic               ev_valid_reg, ev_kind_reg, shut_reg, down_reg;
    logic [15:0]        ev_key_reg;

    logic               in_accept, out_accept, cfg_write, lookup_done;
    logic               mem_wr_en;
    logic [SLOT_W-1:0]  mem_wr_addr;
    slot_entry_t        mem_wr_data, rd_entry;

    logic               ev_valid_c, ev_kind_c, shut_c, down_c;
    logic               deadline_hit;
    logic [63:0]        delay_sum, interval_sum;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_code_reg     <= ESCAPE_CODE_RST;
            initial_delay_reg   <= INITIAL_DELAY_RST;
            repeat_interval_reg <= REPEAT_INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ESCAPE_CODE:     escape_code_reg     <= pwdata[15:0];
                REG_INITIAL_DELAY:   initial_delay_reg   <= pwdata;
                REG_REPEAT_INTERVAL: repeat_interval_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ESCAPE_CODE:     prdata = {16'd0, escape_code_reg};
            REG_INITIAL_DELAY:   prdata = initial_delay_reg;
            REG_REPEAT_INTERVAL: prdata = repeat_interval_reg;
            default:             prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign out_accept  = out_valid_reg && !out_stall;
    assign lookup_done = (state_reg == ST_LOOKUP) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // Slot memory
    // ------------------------------------------------------------------
    kbtr_slot_mem #(
        .DEPTH  (KEY_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_slot_mem (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (key_code[SLOT_W-1:0]),
        .rd_data (rd_entry),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // ------------------------------------------------------------------
    // Input capture
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg      <= cmd_t'(command);
            key_reg      <= key_code;
            now_reg      <= now_ticks;
            in_range_reg <= (key_code < 16'(KEY_SLOTS));
        end
    end

    // ------------------------------------------------------------------
    // Read-modify-write of the looked-up slot
    // ------------------------------------------------------------------
    assign delay_sum    = now_reg + 64'(initial_delay_reg);
    assign interval_sum = now_reg + 64'(repeat_interval_reg);
    assign deadline_hit = (now_reg >= rd_entry.deadline);

    always_comb
    begin
        ev_valid_c       = 1'b0;
        ev_kind_c        = 1'b0;
        shut_c           = 1'b0;
        down_c           = 1'b0;
        repeat_slot_next = repeat_slot_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = key_reg[SLOT_W-1:0];
        mem_wr_data      = rd_entry;

        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_data = '0;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_PRESS:
                begin
                    shut_c = (key_reg == escape_code_reg);
                    if (in_range_reg && !rd_entry.pressed)
                    begin
                        ev_valid_c           = 1'b1;
                        mem_wr_data.pressed  = 1'b1;
                        mem_wr_data.deadline = delay_sum;
                        mem_wr_en            = lookup_done;
                        if (lookup_done)
                        begin
                            repeat_slot_next = key_reg[SLOT_W-1:0];
                        end
                    end
                end
                CMD_HELD:
                begin
                    if ((key_reg == 16'(repeat_slot_reg)) && in_range_reg
                        && rd_entry.pressed && deadline_hit)
                    begin
                        ev_valid_c           = 1'b1;
                        mem_wr_data.deadline = interval_sum;
                        mem_wr_en            = lookup_done;
                    end
                end
                CMD_RELEASE:
                begin
                    if (in_range_reg && rd_entry.pressed)
                    begin
                        ev_valid_c          = 1'b1;
                        ev_kind_c           = 1'b1;
                        mem_wr_data.pressed = 1'b0;
                        mem_wr_en           = lookup_done;
                        // drop the repeat key when it is the one released
                        if (lookup_done && (repeat_slot_reg == key_reg[SLOT_W-1:0]))
                        begin
                            repeat_slot_next = '0;
                        end
                    end
                end
                CMD_QUERY:
                begin
                    down_c = in_range_reg && rd_entry.pressed;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (lookup_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            repeat_slot_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            repeat_slot_reg <= repeat_slot_next;
            if (lookup_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (lookup_done)
        begin
            ev_valid_reg <= ev_valid_c;
            ev_kind_reg  <= ev_kind_c;
            ev_key_reg   <= ev_valid_c ? key_reg : 16'd0;
            shut_reg     <= shut_c;
            down_reg     <= down_c;
        end
    end

    assign event_valid      = ev_valid_reg;
    assign event_kind       = ev_kind_reg;
    assign event_key        = ev_key_reg;
    assign shutdown_request = shut_reg;
    assign key_down         = down_reg;

endmodule
